@@ rtl/hdt_pkg.sv @@
// shared types, codes and defaults for the held note duration table
package hdt_pkg;

  // default sizes
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 32;

  // action codes
  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_FRAME    = 2'd2;

  // status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RECORD   = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  note_value;
    logic [6:0]  note_velocity;
    logic [31:0] time_us;
  } event_item_t;

  // result item
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  done_note;
    logic [6:0]  done_velocity;
    logic [31:0] start_us;
    logic [31:0] duration_us;
    logic        last;
  } record_item_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic pop;
    logic push;
    logic mark;
  } cell_ctrl_t;

endpackage

@@ rtl/held_note_duration_table_core.sv @@
// top level of the held note duration table: control sequencer over a row of entry cells
//
// Held notes live in a row of TABLE_DEPTH cells kept packed toward the head, in
// arrival order. A note-on is taken, then in ON_WAIT its status item is loaded
// into the output register once that is free. A frame boundary or an unused
// action gives no item. A note-off rotates the row one entry past the head per
// cycle while no record is stalled at the output, once to report undelivered
// matches and once to report delivered matches while dropping every match, then
// passes through FLUSH when any record was produced. Each completed note record
// is held until the next is found, so last can be set; a stalled record output
// holds the shift. The next item is taken only when the previous one is
// finished, while its final result may still wait to be taken.
module held_note_duration_table_core import hdt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         event_valid,
  output logic         event_ready,
  input  event_item_t  event_item,
  output logic         record_valid,
  input  logic         record_ready,
  output record_item_t record_item
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE,
    ON_WAIT,
    PASS0,
    PASS1,
    FLUSH
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      scan_len;
  logic [CW-1:0]      step;
  logic [6:0]         key;
  logic [TIME_BITS-1:0] now;
  logic [1:0]         on_status;
  logic               hold_valid;
  record_item_t       hold;

  // row of cells
  logic                 c_valid     [TABLE_DEPTH];
  logic [6:0]           c_note      [TABLE_DEPTH];
  logic [6:0]           c_velocity  [TABLE_DEPTH];
  logic [TIME_BITS-1:0] c_start     [TABLE_DEPTH];
  logic                 c_delivered [TABLE_DEPTH];

  cell_ctrl_t           ctrl;
  logic [6:0]           push_note;
  logic [6:0]           push_velocity;
  logic [TIME_BITS-1:0] push_start;
  logic                 push_delivered;

  logic                 accept;
  logic                 free;
  logic                 head_match;
  logic                 emit;
  logic                 advance;
  logic                 scan_end;
  logic [TIME_BITS-1:0] diff;
  record_item_t         head_rec;
  logic                 out_load;
  record_item_t         out_rec;

  assign event_ready = (state == IDLE);

  // head inspection and step control
  always_comb begin
    accept     = event_valid && event_ready;
    free       = !record_valid || record_ready;
    head_match = c_valid[0] && (c_note[0] == key);
    case (state)
      PASS0:   emit = head_match && !c_delivered[0];
      PASS1:   emit = head_match && c_delivered[0];
      default: emit = 1'b0;
    endcase
    advance  = ((state == PASS0) || (state == PASS1)) && (!emit || !hold_valid || free);
    scan_end = ((step + 1'b1) == scan_len);
    diff     = now - c_start[0];

    head_rec.status        = ST_RECORD;
    head_rec.done_note     = key;
    head_rec.done_velocity = c_velocity[0];
    head_rec.start_us      = 32'(c_start[0]);
    head_rec.duration_us   = 32'(diff);
    head_rec.last          = 1'b0;
  end

  // next item for the output register
  always_comb begin
    out_load = 1'b0;
    out_rec  = hold;
    case (state)
      ON_WAIT: begin
        out_load       = free;
        out_rec        = '0;
        out_rec.status = on_status;
        out_rec.last   = 1'b1;
      end
      PASS0, PASS1: begin
        out_load = advance && emit && hold_valid;
      end
      FLUSH: begin
        out_load     = free;
        out_rec.last = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // row controls and push data
  always_comb begin
    ctrl           = '0;
    push_note      = c_note[0];
    push_velocity  = c_velocity[0];
    push_start     = c_start[0];
    push_delivered = c_delivered[0];
    if (accept) begin
      case (event_item.action)
        ACT_NOTE_ON: begin
          ctrl.push      = (count < CW'(TABLE_DEPTH));
          push_note      = event_item.note_value;
          push_velocity  = event_item.note_velocity;
          push_start     = TIME_BITS'(event_item.time_us);
          push_delivered = 1'b0;
        end
        ACT_FRAME: begin
          ctrl.mark = 1'b1;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end else if (advance) begin
      ctrl.pop  = 1'b1;
      ctrl.push = (state == PASS0) || !head_match;
    end
  end

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                 nv;
    logic [6:0]           nn;
    logic [6:0]           nvel;
    logic [TIME_BITS-1:0] ns;
    logic                 nd;
    logic                 pv;

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nv   = 1'b0;
      assign nn   = '0;
      assign nvel = '0;
      assign ns   = '0;
      assign nd   = 1'b0;
    end else begin : g_mid
      assign nv   = c_valid[i+1];
      assign nn   = c_note[i+1];
      assign nvel = c_velocity[i+1];
      assign ns   = c_start[i+1];
      assign nd   = c_delivered[i+1];
    end

    if (i == 0) begin : g_head
      assign pv = 1'b1;
    end else begin : g_prev
      assign pv = c_valid[i-1];
    end

    hdt_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .prev_valid     (pv),
      .next_valid     (nv),
      .next_note      (nn),
      .next_velocity  (nvel),
      .next_start     (ns),
      .next_delivered (nd),
      .push_note      (push_note),
      .push_velocity  (push_velocity),
      .push_start     (push_start),
      .push_delivered (push_delivered),
      .valid          (c_valid[i]),
      .note           (c_note[i]),
      .velocity       (c_velocity[i]),
      .start          (c_start[i]),
      .delivered      (c_delivered[i])
    );
  end

  // sequencer, held record and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      count        <= '0;
      step         <= '0;
      hold_valid   <= 1'b0;
      record_valid <= 1'b0;
    end else begin
      if (out_load) begin
        record_item  <= out_rec;
        record_valid <= 1'b1;
      end else if (record_valid && record_ready) begin
        record_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            case (event_item.action)
              ACT_NOTE_ON: begin
                if (count < CW'(TABLE_DEPTH)) begin
                  count     <= count + 1'b1;
                  on_status <= ST_ACCEPTED;
                end else begin
                  on_status <= ST_FULL;
                end
                state <= ON_WAIT;
              end
              ACT_NOTE_OFF: begin
                key      <= event_item.note_value;
                now      <= TIME_BITS'(event_item.time_us);
                scan_len <= count;
                step     <= '0;
                if (count != '0) begin
                  state <= PASS0;
                end
              end
              default: begin
                state <= IDLE;
              end
            endcase
          end
        end
        ON_WAIT: begin
          if (free) begin
            state <= IDLE;
          end
        end
        PASS0, PASS1: begin
          if (advance) begin
            if (emit) begin
              hold       <= head_rec;
              hold_valid <= 1'b1;
            end
            if ((state == PASS1) && head_match) begin
              count <= count - 1'b1;
            end
            if (scan_end) begin
              step <= '0;
              if (state == PASS0) begin
                state <= PASS1;
              end else if (hold_valid || emit) begin
                state <= FLUSH;
              end else begin
                state <= IDLE;
              end
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        FLUSH: begin
          if (free) begin
            hold_valid <= 1'b0;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/hdt_cell.sv @@
// one entry of the held note row: shifts toward the head, takes a pushed entry at the tail
module hdt_cell import hdt_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic                 prev_valid,
  input  logic                 next_valid,
  input  logic [6:0]           next_note,
  input  logic [6:0]           next_velocity,
  input  logic [TIME_BITS-1:0] next_start,
  input  logic                 next_delivered,
  input  logic [6:0]           push_note,
  input  logic [6:0]           push_velocity,
  input  logic [TIME_BITS-1:0] push_start,
  input  logic                 push_delivered,
  output logic                 valid,
  output logic [6:0]           note,
  output logic [6:0]           velocity,
  output logic [TIME_BITS-1:0] start,
  output logic                 delivered
);

  logic take_push;
  logic take_next;

  // this cell is the first free one after the shift, or now when there is no shift
  always_comb begin
    if (ctrl.pop) begin
      take_push = ctrl.push && valid && !next_valid;
    end else begin
      take_push = ctrl.push && !valid && prev_valid;
    end
    take_next = ctrl.pop && !take_push;
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_push) begin
      valid <= 1'b1;
    end else if (take_next) begin
      valid <= next_valid;
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (take_push) begin
      note      <= push_note;
      velocity  <= push_velocity;
      start     <= push_start;
      delivered <= push_delivered;
    end else if (take_next) begin
      note      <= next_note;
      velocity  <= next_velocity;
      start     <= next_start;
      delivered <= next_delivered;
    end else if (ctrl.mark) begin
      delivered <= 1'b1;
    end
  end

endmodule

@@ rtl/hdt_checker.sv @@
// port-level checks for the held note duration table, bound to the top level
module hdt_checker import hdt_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         event_valid,
  input logic         event_ready,
  input event_item_t  event_item,
  input logic         record_valid,
  input logic         record_ready,
  input record_item_t record_item
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    record_valid && !record_ready |=> record_valid && $stable(record_item))
    else $error("stalled record item changed");

  // a note-on keeps the block busy for at least its result cycle
  assert property (@(posedge clk) disable iff (rst)
    event_valid && event_ready && (event_item.action == ACT_NOTE_ON) |=> !event_ready)
    else $error("input taken right after a note-on");

  // a record that is not the last of its note-off means more work is pending
  assert property (@(posedge clk) disable iff (rst)
    record_valid && (record_item.status == ST_RECORD) && !record_item.last |-> !event_ready)
    else $error("idle while a note-off still owes records");

  // status items of a note-on are always single and last
  assert property (@(posedge clk) disable iff (rst)
    record_valid && (record_item.status != ST_RECORD) |-> record_item.last)
    else $error("note-on status without last");

endmodule

bind held_note_duration_table_core hdt_checker u_hdt_checker (
  .clk          (clk),
  .rst          (rst),
  .event_valid  (event_valid),
  .event_ready  (event_ready),
  .event_item   (event_item),
  .record_valid (record_valid),
  .record_ready (record_ready),
  .record_item  (record_item)
);

@@ verif/tb.sv @@
// testbench for held_note_duration_table_core: directed script plus random note traffic
module tb;
  import hdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH       = DEF_TABLE_DEPTH;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          RANDOM_ITEMS = 100;
  localparam int          PRESSURE_AT = 60;
  localparam int          PRESSURE_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 4 * (2 * DEPTH + 2) + 100;

  localparam record_item_t ACCEPT_REC = '{status: ST_ACCEPTED, done_note: '0,
                                          done_velocity: '0, start_us: '0,
                                          duration_us: '0, last: 1'b1};
  localparam record_item_t FULL_REC   = '{status: ST_FULL, done_note: '0,
                                          done_velocity: '0, start_us: '0,
                                          duration_us: '0, last: 1'b1};
  localparam record_item_t NO_REC     = '0;

  logic         clk;
  logic         rst;
  logic         event_valid;
  logic         event_ready;
  event_item_t  event_item;
  logic         record_valid;
  logic         record_ready;
  record_item_t record_item;

  held_note_duration_table_core dut (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_item   (event_item),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record_item  (record_item)
  );

  // one row of the directed script
  typedef struct {
    event_item_t  ev;
    int unsigned  reps;
    bit           typed;
    record_item_t want;
  } script_row_t;

  // mirror of the held-note table
  logic [6:0]  held_note  [DEPTH];
  logic [6:0]  held_vel   [DEPTH];
  logic [31:0] held_start [DEPTH];
  bit          held_sent  [DEPTH];
  int          held_count;

  record_item_t expected_records[$];
  script_row_t  script[$];

  int          mismatch_count;
  int          records_seen;
  int          quiet_cycles;
  bit          no_idle;
  bit          pressure_done;
  logic [31:0] clock_us;
  logic [6:0]  note_pool[4];

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    end
  endtask

  // append one expected result item
  task automatic queue_record(input record_item_t rec);
    expected_records.insert(expected_records.size(), rec);
  endtask

  // table update and expected records for one accepted item
  task automatic predict_event(input event_item_t ev);
    record_item_t rec;
    int           keep;
    int           found;
    found = 0;
    case (ev.action)
      ACT_NOTE_ON: begin
        rec = ACCEPT_REC;
        if (held_count >= DEPTH) begin
          rec = FULL_REC;
        end else begin
          held_note[held_count]  = ev.note_value;
          held_vel[held_count]   = ev.note_velocity;
          held_start[held_count] = ev.time_us;
          held_sent[held_count]  = 1'b0;
          held_count++;
        end
        queue_record(rec);
      end
      ACT_FRAME: begin
        for (int i = 0; i < held_count; i++) held_sent[i] = 1'b1;
      end
      ACT_NOTE_OFF: begin
        // undelivered matches first, then delivered ones
        for (int pass = 0; pass < 2; pass++) begin
          for (int i = 0; i < held_count; i++) begin
            if (held_note[i] == ev.note_value && held_sent[i] == pass[0]) begin
              rec.status        = ST_RECORD;
              rec.done_note     = ev.note_value;
              rec.done_velocity = held_vel[i];
              rec.start_us      = held_start[i];
              rec.duration_us   = ev.time_us - held_start[i];
              rec.last          = 1'b0;
              queue_record(rec);
              found++;
            end
          end
        end
        if (found > 0) expected_records[expected_records.size() - 1].last = 1'b1;
        // compact the survivors in order
        keep = 0;
        for (int i = 0; i < held_count; i++) begin
          if (held_note[i] != ev.note_value) begin
            held_note[keep]  = held_note[i];
            held_vel[keep]   = held_vel[i];
            held_start[keep] = held_start[i];
            held_sent[keep]  = held_sent[i];
            keep++;
          end
        end
        held_count = keep;
      end
      default: ;
    endcase
  endtask

  // gap length: mostly none or short, a few long
  function automatic int pick_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_event(input event_item_t ev, input bit typed,
                            input record_item_t want);
    int gap;
    int depth_before;
    gap = pick_idle();
    if (gap > 0) begin
      event_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    event_item  = ev;
    event_valid = 1'b1;
    do @(posedge clk); while (!event_ready);
    depth_before = expected_records.size();
    predict_event(ev);
    if (typed) begin
      while (expected_records.size() > depth_before) void'(expected_records.pop_back());
      queue_record(want);
    end
    @(negedge clk);
  endtask

  // append one row to the directed script
  task automatic add_row(input logic [1:0] act, input logic [6:0] nt,
                         input logic [6:0] vel, input logic [31:0] us,
                         input int unsigned reps, input bit typed,
                         input record_item_t want);
    script_row_t r;
    r.ev.action        = act;
    r.ev.note_value    = nt;
    r.ev.note_velocity = vel;
    r.ev.time_us       = us;
    r.reps             = reps;
    r.typed            = typed;
    r.want             = want;
    script.insert(script.size(), r);
  endtask

  // random item, mostly on a small pool of notes, with time mostly moving forward
  function automatic event_item_t make_random_event(input bit force_on);
    event_item_t ev;
    int          r;
    r = $urandom_range(0, 99);
    if (force_on || r < 40) ev.action = ACT_NOTE_ON;
    else if (r < 75) ev.action = ACT_NOTE_OFF;
    else if (r < 93) ev.action = ACT_FRAME;
    else ev.action = ACT_UNUSED;
    if ($urandom_range(0, 4) != 0) ev.note_value = note_pool[$urandom_range(0, 3)];
    else ev.note_value = 7'($urandom_range(0, 127));
    ev.note_velocity = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 9) == 0) clock_us = $urandom();
    else clock_us = clock_us + 32'($urandom_range(0, 2000));
    ev.time_us = clock_us;
    return ev;
  endfunction

  // result checker
  always @(posedge clk) begin
    record_item_t want;
    if (!rst && record_valid && record_ready) begin
      records_seen++;
      if (expected_records.size() == 0) begin
        report_mismatch("unexpected record", 32'(record_item.status), 32'd0);
      end else begin
        want = expected_records.pop_front();
        if (record_item.status != want.status)
          report_mismatch("status", 32'(record_item.status), 32'(want.status));
        if (record_item.done_note != want.done_note)
          report_mismatch("done_note", 32'(record_item.done_note), 32'(want.done_note));
        if (record_item.done_velocity != want.done_velocity)
          report_mismatch("done_velocity", 32'(record_item.done_velocity),
                          32'(want.done_velocity));
        if (record_item.start_us != want.start_us)
          report_mismatch("start_us", record_item.start_us, want.start_us);
        if (record_item.duration_us != want.duration_us)
          report_mismatch("duration_us", record_item.duration_us, want.duration_us);
        if (record_item.last != want.last)
          report_mismatch("last", 32'(record_item.last), 32'(want.last));
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (event_valid && event_ready) || (record_valid && record_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("held_note_duration_table_core test failed");
        $finish;
      end
    end
  end

  // record side: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    record_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!pressure_done && records_seen >= PRESSURE_AT) begin
        record_ready = 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end else begin
        stall = pick_idle();
        if (stall > 0) begin
          record_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        record_ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int          random_count;
    int          burst;
    event_item_t ev;
    rst            = 1'b1;
    event_valid    = 1'b0;
    event_item     = '0;
    held_count     = 0;
    mismatch_count = 0;
    records_seen   = 0;
    quiet_cycles   = 0;
    no_idle        = 1'b0;
    pressure_done  = 1'b0;
    clock_us       = 32'd0;
    for (int i = 0; i < DEPTH; i++) begin
      held_note[i]  = '0;
      held_vel[i]   = '0;
      held_start[i] = '0;
      held_sent[i]  = 1'b0;
    end

    // empty table cases, field extremes and wrap of the duration
    add_row(ACT_NOTE_OFF, 7'd127, 7'd0, 32'd5, 1, 1'b0, NO_REC);
    add_row(ACT_FRAME, 7'd0, 7'd0, 32'd6, 1, 1'b0, NO_REC);
    add_row(ACT_UNUSED, 7'd127, 7'd127, 32'hFFFF_FFFF, 1, 1'b0, NO_REC);
    add_row(ACT_NOTE_ON, 7'd0, 7'd0, 32'd0, 1, 1'b1, ACCEPT_REC);
    add_row(ACT_NOTE_ON, 7'd127, 7'd127, 32'hFFFF_FFFF, 1, 1'b1, ACCEPT_REC);
    add_row(ACT_NOTE_OFF, 7'd0, 7'd55, 32'hFFFF_FFFF, 1, 1'b1,
            '{status: ST_RECORD, done_note: 7'd0, done_velocity: 7'd0,
              start_us: 32'd0, duration_us: 32'hFFFF_FFFF, last: 1'b1});
    add_row(ACT_NOTE_OFF, 7'd127, 7'd0, 32'd0, 1, 1'b1,
            '{status: ST_RECORD, done_note: 7'd127, done_velocity: 7'd127,
              start_us: 32'hFFFF_FFFF, duration_us: 32'd1, last: 1'b1});
    // fill the table, partly delivered, then overflow
    add_row(ACT_NOTE_ON, 7'd9, 7'd1, 32'd100, 7, 1'b1, ACCEPT_REC);
    add_row(ACT_FRAME, 7'd9, 7'd0, 32'd150, 1, 1'b0, NO_REC);
    add_row(ACT_NOTE_ON, 7'd9, 7'd2, 32'd200, 8, 1'b1, ACCEPT_REC);
    add_row(ACT_NOTE_ON, 7'd3, 7'd64, 32'd300, 1, 1'b1, ACCEPT_REC);
    add_row(ACT_NOTE_ON, 7'd5, 7'd5, 32'd400, 1, 1'b1, FULL_REC);
    // release with many matches, undelivered ahead of delivered
    add_row(ACT_NOTE_OFF, 7'd9, 7'd0, 32'd1000, 1, 1'b0, NO_REC);
    add_row(ACT_NOTE_OFF, 7'd3, 7'd0, 32'd250, 1, 1'b0, NO_REC);
    add_row(ACT_NOTE_OFF, 7'd3, 7'd0, 32'd260, 1, 1'b0, NO_REC);

    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      repeat (script[i].reps) send_event(script[i].ev, script[i].typed, script[i].want);
    end

    // random traffic
    foreach (note_pool[i]) note_pool[i] = 7'($urandom_range(0, 127));
    clock_us     = $urandom();
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 7) == 0) begin
        // burst of presses, often up to a full table
        burst = $urandom_range(6, 18);
        repeat (burst) begin
          send_event(make_random_event(1'b1), 1'b0, NO_REC);
          random_count++;
        end
      end else begin
        ev = make_random_event(1'b0);
        send_event(ev, 1'b0, NO_REC);
        random_count++;
      end
    end
    event_valid = 1'b0;

    // drain
    while (expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_records.size() == 0) begin
      $display("held_note_duration_table_core test passed");
    end else begin
      $display("held_note_duration_table_core test failed");
    end
    $finish;
  end

endmodule

@@ held_note_duration_table_core.f @@
rtl/hdt_pkg.sv
rtl/hdt_cell.sv
rtl/held_note_duration_table_core.sv
rtl/hdt_checker.sv
verif/tb.sv
